@@ hw/rtl/laplacian_edge_3x3_defines.svh @@
// assertion macros shared by the laplacian edge filter rtl
`ifndef LAPLACIAN_EDGE_3X3_DEFINES_SVH
`define LAPLACIAN_EDGE_3X3_DEFINES_SVH

// property checked on every rising clk edge outside reset
`define LPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define LPE_NEVER(lbl, cond, msg) \
	`LPE_ASSERT(lbl, !(cond), msg)

`endif

@@ hw/rtl/lpe_pkg.sv @@
// types, constants and mask table of the laplacian edge filter
package lpe_pkg;

	localparam int unsigned MAX_LINE_WIDTH = 1024;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned COL_W = $clog2(MAX_LINE_WIDTH);
	localparam int unsigned FILL_W = COL_W + 1;
	localparam int unsigned LW_W = 11;
	localparam int unsigned CMP_W = (FILL_W > LW_W) ? FILL_W : LW_W;
	localparam int unsigned SUM_W = 13;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = FIFO_AW + 2;

	typedef logic [COL_W-1:0] col_t;
	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [CMP_W-1:0] cmp_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	localparam logic [LW_W-1:0] LINE_WIDTH_RST = 11'd640;
	localparam cmp_t WIDTH_MIN = cmp_t'(3);
	localparam cmp_t WIDTH_MAX = cmp_t'(MAX_LINE_WIDTH);
	localparam fill_t FILL_MAX = fill_t'(MAX_LINE_WIDTH);
	localparam cnt_t FIFO_FULL = cnt_t'(FIFO_DEPTH);

	// register indexes (byte address bit 2)
	localparam logic REG_LINE_WIDTH = 1'b0;
	localparam logic REG_MASK_SELECT = 1'b1;

	// mask codes
	localparam logic [1:0] MASK_FOUR = 2'd0;
	localparam logic [1:0] MASK_FOUR_NEG = 2'd1;
	localparam logic [1:0] MASK_EIGHT = 2'd2;
	localparam logic [1:0] MASK_DIAG = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic start_of_frame;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] edge_value;
		logic window_valid;
	} edge_t;

	// pixel on its way through the read stage
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		col_t col;
		logic win_ok;
	} item_t;

	// right-hand window column taken from the line buffers
	typedef struct packed {
		logic [PIX_W-1:0] two_above;
		logic [PIX_W-1:0] above;
	} column_t;

	// coefficient at window position pos (row-major, oldest row first)
	function automatic logic signed [4:0] mask_coef(input logic [1:0] sel,
			input logic [3:0] pos);
		logic signed [4:0] c;
		logic center;
		logic edge_mid;
		center = (pos == 4'd4);
		edge_mid = (pos == 4'd1) || (pos == 4'd3) || (pos == 4'd5) || (pos == 4'd7);
		case (sel)
			MASK_FOUR: begin
				c = center ? 5'sd4 : (edge_mid ? -5'sd1 : 5'sd0);
			end
			MASK_FOUR_NEG: begin
				c = center ? -5'sd4 : (edge_mid ? 5'sd1 : 5'sd0);
			end
			MASK_EIGHT: begin
				c = center ? 5'sd8 : -5'sd1;
			end
			MASK_DIAG: begin
				c = center ? 5'sd4 : (edge_mid ? -5'sd2 : 5'sd1);
			end
			default: begin
				c = 5'sd0;
			end
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/laplacian_edge_3x3.sv @@
// top level of the streaming 3x3 laplacian edge filter
// Streaming 3x3 Laplacian edge filter for 8-bit grey pixels in raster order. It takes one
// pixel per clock while not stalled and gives one result per pixel, in order: the clamped
// (0..255) response of the selected mask over the window whose bottom-right corner is that
// pixel, plus a flag that the window lies fully inside the image (value 0 otherwise). The
// line buffer read registers at the pixel transfer edge, then the weighted sum is registered,
// and the result then enters the output queue, from which it is offered. The line buffers
// are single-write, single-read memories that are read and written once per pixel, which
// sets the one-pixel-per-clock rate. A four entry queue holds results; the input stalls once
// four results are queued or in flight, so the input keeps flowing while a finished result
// waits. Line buffer entries never written since reset read as zero through a fill count, so
// there is no clearing pass after reset. Registers: line_width at byte 0 (pixels per row,
// clamped to 3..1024 in use, reset 640), mask_select at byte 4 (0 four-neighbour, 1 negated
// four-neighbour, 2 eight-neighbour, 3 diagonal). Change them only while the block is idle.
module laplacian_edge_3x3 (
	input  logic            clk,
	input  logic            arst_n,
	// pixel channel
	input  logic            pix_valid,
	output logic            pix_stall,
	input  lpe_pkg::pix_t   pix,
	// result channel
	output logic            res_valid,
	input  logic            res_stall,
	output lpe_pkg::edge_t  res,
	// configuration port
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	// configuration registers
	logic [lpe_pkg::LW_W-1:0] line_width_q;
	logic [1:0] mask_sel_q;
	logic cfg_wr;

	// position in the frame
	lpe_pkg::col_t col_q;
	logic [1:0] row_q;
	lpe_pkg::col_t col_cur;
	logic [1:0] row_cur;
	lpe_pkg::cmp_t width_use;
	lpe_pkg::cmp_t col_end;
	logic wrap;

	// pipeline
	logic accept;
	logic valid_s1;
	lpe_pkg::item_t item_s1;
	lpe_pkg::column_t column;
	logic valid_s2;
	lpe_pkg::edge_t result;
	lpe_pkg::cnt_t queue_count;
	lpe_pkg::cnt_t in_flight;

	// configuration port: always ready, register index is address bit 2
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= lpe_pkg::LINE_WIDTH_RST;
			mask_sel_q <= lpe_pkg::MASK_FOUR;
		end else if (cfg_wr) begin
			case (paddr[2])
				lpe_pkg::REG_LINE_WIDTH: begin
					line_width_q <= pwdata[lpe_pkg::LW_W-1:0];
				end
				lpe_pkg::REG_MASK_SELECT: begin
					mask_sel_q <= pwdata[1:0];
				end
				default: begin
					line_width_q <= line_width_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lpe_pkg::REG_LINE_WIDTH: begin
				prdata = 32'(line_width_q);
			end
			lpe_pkg::REG_MASK_SELECT: begin
				prdata = 32'(mask_sel_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// width in use, clamped to the supported range
	always_comb begin
		if (lpe_pkg::cmp_t'(line_width_q) < lpe_pkg::WIDTH_MIN) begin
			width_use = lpe_pkg::WIDTH_MIN;
		end else if (lpe_pkg::cmp_t'(line_width_q) > lpe_pkg::WIDTH_MAX) begin
			width_use = lpe_pkg::WIDTH_MAX;
		end else begin
			width_use = lpe_pkg::cmp_t'(line_width_q);
		end
	end

	// start of frame puts the pixel at row 0, column 0
	assign col_cur = pix.start_of_frame ? '0 : col_q;
	assign row_cur = pix.start_of_frame ? 2'd0 : row_q;
	assign col_end = lpe_pkg::cmp_t'(col_cur) + lpe_pkg::cmp_t'(1);
	assign wrap = (col_end >= width_use);

	// credit check: queued plus in-flight results must fit the queue
	assign in_flight = lpe_pkg::cnt_t'(valid_s1) + lpe_pkg::cnt_t'(valid_s2) + queue_count;
	assign pix_stall = (in_flight >= lpe_pkg::FIFO_FULL);
	assign accept = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 2'd0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (wrap) begin
					col_q <= '0;
					// row count saturates at two
					if (row_cur != 2'd2) begin
						row_q <= row_cur + 2'd1;
					end else begin
						row_q <= row_cur;
					end
				end else begin
					col_q <= col_cur + lpe_pkg::col_t'(1);
					row_q <= row_cur;
				end
			end
		end
	end

	// pixel waits here while its line buffer column is read
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.pixel <= pix.pixel;
			item_s1.col <= col_cur;
			item_s1.win_ok <= (row_cur == 2'd2) && (col_cur >= lpe_pkg::col_t'(2));
		end
	end

	lpe_linebuf u_linebuf (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(col_cur),
		.wr_en(valid_s1),
		.item(item_s1),
		.column(column)
	);

	lpe_kernel u_kernel (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.item_s1(item_s1),
		.column(column),
		.mask_sel(mask_sel_q),
		.valid_s2(valid_s2),
		.result(result)
	);

	lpe_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(valid_s2),
		.push_data(result),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.count(queue_count)
	);

endmodule

@@ hw/rtl/lpe_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module lpe_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/lpe_linebuf.sv @@
// two line buffers with fill tracking and write-to-read forwarding
`include "laplacian_edge_3x3_defines.svh"

module lpe_linebuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  lpe_pkg::col_t     rd_addr,
	input  logic              wr_en,
	input  lpe_pkg::item_t    item,
	output lpe_pkg::column_t  column
);

	logic [lpe_pkg::PIX_W-1:0] rd_above;
	logic [lpe_pkg::PIX_W-1:0] rd_two;
	lpe_pkg::fill_t fill_q;
	logic fwd_q;
	logic [lpe_pkg::PIX_W-1:0] fwd_above_q;
	logic [lpe_pkg::PIX_W-1:0] fwd_two_q;
	logic unwritten;

	lpe_ram #(
		.WIDTH(lpe_pkg::PIX_W),
		.DEPTH(lpe_pkg::MAX_LINE_WIDTH)
	) u_ram_above (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(item.col),
		.wr_data(item.pixel),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_above)
	);

	lpe_ram #(
		.WIDTH(lpe_pkg::PIX_W),
		.DEPTH(lpe_pkg::MAX_LINE_WIDTH)
	) u_ram_two (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(item.col),
		.wr_data(column.above),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_two)
	);

	// entries are always written as a prefix 0..fill-1, the rest read as zero
	assign unwritten = (lpe_pkg::fill_t'(item.col) >= fill_q);

	always_comb begin
		if (fwd_q) begin
			column.above = fwd_above_q;
			column.two_above = fwd_two_q;
		end else if (unwritten) begin
			column.above = '0;
			column.two_above = '0;
		end else begin
			column.above = rd_above;
			column.two_above = rd_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			fwd_q <= 1'b0;
		end else begin
			if (wr_en && unwritten) begin
				fill_q <= lpe_pkg::fill_t'(item.col) + lpe_pkg::fill_t'(1);
			end
			if (rd_en) begin
				fwd_q <= wr_en && (rd_addr == item.col);
			end
		end
	end

	// data written this cycle, seen by a read of the same entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_above_q <= item.pixel;
			fwd_two_q <= column.above;
		end
	end

	`LPE_NEVER(a_fwd_only_col_zero, wr_en && fwd_q && (item.col != '0), "forward off column zero")
	`LPE_NEVER(a_fill_no_gap, wr_en && (lpe_pkg::fill_t'(item.col) > fill_q), "write past fill")
	`LPE_NEVER(a_fill_in_range, fill_q > lpe_pkg::FILL_MAX, "fill count out of range")

endmodule

@@ hw/rtl/lpe_kernel.sv @@
// window columns, weighted sum and clamp
module lpe_kernel (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  lpe_pkg::item_t    item_s1,
	input  lpe_pkg::column_t  column,
	input  logic [1:0]        mask_sel,
	output logic              valid_s2,
	output lpe_pkg::edge_t    result
);

	logic [lpe_pkg::PIX_W-1:0] wc_q [6];
	logic [lpe_pkg::PIX_W-1:0] win [9];
	logic signed [4:0] coef;
	lpe_pkg::sum_t sum;
	lpe_pkg::sum_t sum_s2;
	logic win_ok_s2;
	logic valid_s2_q;

	// entries 0..2 column two left, 3..5 column one left, oldest row first
	always_comb begin
		win[0] = wc_q[0];
		win[1] = wc_q[3];
		win[2] = column.two_above;
		win[3] = wc_q[1];
		win[4] = wc_q[4];
		win[5] = column.above;
		win[6] = wc_q[2];
		win[7] = wc_q[5];
		win[8] = item_s1.pixel;
	end

	always_comb begin
		sum = '0;
		coef = '0;
		for (int p = 0; p < 9; p++) begin
			coef = lpe_pkg::mask_coef(mask_sel, 4'(p));
			sum = sum + lpe_pkg::sum_t'(win[p]) * lpe_pkg::sum_t'(coef);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				wc_q[i] <= '0;
			end
			valid_s2_q <= 1'b0;
		end else begin
			valid_s2_q <= valid_s1;
			if (valid_s1) begin
				for (int i = 0; i < 3; i++) begin
					wc_q[i] <= wc_q[3 + i];
				end
				wc_q[3] <= column.two_above;
				wc_q[4] <= column.above;
				wc_q[5] <= item_s1.pixel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sum_s2 <= sum;
			win_ok_s2 <= item_s1.win_ok;
		end
	end

	always_comb begin
		result.window_valid = win_ok_s2;
		if (!win_ok_s2 || sum_s2[lpe_pkg::SUM_W-1]) begin
			result.edge_value = '0;
		end else if (|sum_s2[lpe_pkg::SUM_W-2:lpe_pkg::PIX_W]) begin
			result.edge_value = '1;
		end else begin
			result.edge_value = sum_s2[lpe_pkg::PIX_W-1:0];
		end
	end

	assign valid_s2 = valid_s2_q;

endmodule

@@ hw/rtl/lpe_out_fifo.sv @@
// small result queue that drives the output channel from registers
`include "laplacian_edge_3x3_defines.svh"

module lpe_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lpe_pkg::edge_t  push_data,
	output logic            res_valid,
	input  logic            res_stall,
	output lpe_pkg::edge_t  res,
	output lpe_pkg::cnt_t   count
);

	lpe_pkg::edge_t mem_q [lpe_pkg::FIFO_DEPTH];
	logic [lpe_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [lpe_pkg::FIFO_AW-1:0] rd_ptr_q;
	lpe_pkg::cnt_t count_q;
	logic pop;

	assign res_valid = (count_q != '0);
	assign res = mem_q[rd_ptr_q];
	assign pop = res_valid && !res_stall;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + lpe_pkg::cnt_t'(1);
			end else if (pop && !push) begin
				count_q <= count_q - lpe_pkg::cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`LPE_NEVER(a_no_overflow, push && !pop && (count_q == lpe_pkg::FIFO_FULL), "result queue overflow")

endmodule

@@ bench/tb_laplacian_edge_3x3.sv @@
// self-checking testbench for the streaming 3x3 laplacian edge filter
module tb_laplacian_edge_3x3;
	import lpe_pkg::*;

	// run limits
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 280;
	localparam int MAX_REPORTS = 10;
	localparam int STEP_COUNT = 24;

	// mask weights, one row per mask code in code order:
	// four-neighbour, negated four-neighbour, eight-neighbour, diagonal
	// each row is the 3x3 window, oldest row first, leftmost column first
	localparam int LAP_COEF [4][9] = '{
		'{ 0, -1,  0, -1,  4, -1,  0, -1,  0},
		'{ 0,  1,  0,  1, -4,  1,  0,  1,  0},
		'{-1, -1, -1, -1,  8, -1, -1, -1, -1},
		'{ 1, -2,  1, -2,  4, -2,  1, -2,  1}
	};

	// one row of the directed stimulus: optional register writes, the pixel,
	// and a hand-written result where it is obvious
	typedef struct packed {
		logic cfg;
		logic [10:0] width;
		logic [1:0] mask;
		logic [7:0] pixel;
		logic sof;
		logic typed;
		logic [7:0] exp_value;
		logic exp_valid;
	} step_t;

	// width 0 clamps to 3 throughout, so each 3x3 frame is nine pixels
	step_t directed_steps [STEP_COUNT] = '{
		// no start mark after reset: first pixel is row 0 column 0
		'{1'b1, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0},
		// lone bright centre
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0},
		// four times the centre clamps high
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b1, 8'd255, 1'b1},
		// new frame, flat white under the eight-neighbour mask
		'{1'b1, 11'd0, MASK_EIGHT, 8'd255, 1'b1, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b1, 8'd0, 1'b1},
		// next row under the negated mask, left columns not yet valid
		'{1'b1, 11'd0, MASK_FOUR_NEG, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0},
		// diagonal mask over mixed content
		'{1'b1, 11'd0, MASK_DIAG, 8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0},
		'{1'b0, 11'd0, MASK_FOUR, 8'd255, 1'b0, 1'b0, 8'd0, 1'b0}
	};

	// block inputs, all known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	pix_t pix = '0;
	logic res_stall = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;

	// block outputs
	logic pix_stall;
	logic res_valid;
	edge_t res;
	logic [31:0] prdata;
	logic pready;

	laplacian_edge_3x3 dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 8 unit clock period
	initial begin
		forever #4 clk = ~clk;
	end

	// filter state as the predictor sees it
	logic [7:0] prev_row [MAX_LINE_WIDTH];
	logic [7:0] prev_prev_row [MAX_LINE_WIDTH];
	logic [7:0] left_cols [6];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	logic [10:0] width_reg = LINE_WIDTH_RST;
	logic [1:0] mask_reg = MASK_FOUR;

	// results still owed by the block, oldest first
	edge_t expected_edges [$];
	edge_t oldest;
	int mismatch_count = 0;
	int cycle_count = 0;

	// idle percentages of the two channels, changed per regime
	int send_idle_pct = 16;
	int recv_idle_pct = 54;

	// line buffers and window start out all zero
	initial begin
		foreach (prev_row[i]) begin
			prev_row[i] = '0;
			prev_prev_row[i] = '0;
		end
		foreach (left_cols[i]) begin
			left_cols[i] = '0;
		end
	end

	// advance the filter state by one pixel and return its edge result
	function automatic edge_t edge_of_pixel(input pix_t p);
		int unsigned span;
		int unsigned c;
		logic [7:0] w [3][3];
		int acc;
		edge_t r;
		// width in use is the register clamped to the legal span
		span = int'(width_reg);
		if (span < 3) span = 3;
		if (span > MAX_LINE_WIDTH) span = MAX_LINE_WIDTH;
		// start mark restarts the frame before this pixel is taken
		if (p.start_of_frame) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		for (int m = 0; m < 3; m++) begin
			w[m][0] = left_cols[m];
			w[m][1] = left_cols[3 + m];
		end
		w[0][2] = prev_prev_row[c];
		w[1][2] = prev_row[c];
		w[2][2] = p.pixel;
		acc = 0;
		for (int m = 0; m < 3; m++) begin
			for (int n = 0; n < 3; n++) begin
				acc += int'(w[m][n]) * LAP_COEF[mask_reg][3 * m + n];
			end
		end
		if (acc < 0) acc = 0;
		if (acc > 255) acc = 255;
		r.window_valid = (row_pos >= 2) && (col_pos >= 2);
		r.edge_value = r.window_valid ? acc[7:0] : 8'd0;
		// shift the line buffers and the window
		prev_prev_row[c] = w[1][2];
		prev_row[c] = p.pixel;
		for (int m = 0; m < 3; m++) begin
			left_cols[m] = w[m][1];
			left_cols[3 + m] = w[m][2];
		end
		// row ends once the column reaches the width, even if it was lowered
		if (col_pos + 1 >= span) begin
			col_pos = 0;
			if (row_pos < 2) row_pos++;
		end else begin
			col_pos++;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
		end
	endtask

	// register write then read back, both through setup and access cycles
	task automatic write_reg(input logic idx, input logic [31:0] value);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// register now holds the new value
		case (idx)
			REG_LINE_WIDTH: begin
				width_reg = value[10:0];
				want = {21'd0, value[10:0]};
			end
			REG_MASK_SELECT: begin
				mask_reg = value[1:0];
				want = {30'd0, value[1:0]};
			end
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) report_mismatch("register readback", int'(want), int'(prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		// the port idles before the next access
		@(negedge clk);
	endtask

	// one pixel transfer; entered and left at a falling edge
	task automatic send_pixel(input pix_t p, input logic typed, input edge_t typed_res);
		edge_t predicted;
		// random sender gaps
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (pix_stall);
		// transfer taken at this edge
		predicted = edge_of_pixel(p);
		expected_edges.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	// stop sending and wait until every owed result has come out
	task automatic settle();
		pix_valid <= 1'b0;
		while (expected_edges.size() != 0) @(negedge clk);
	endtask

	// receiver stalls at random per regime
	always @(negedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_edges.size() == 0) begin
				report_mismatch("result with none pending, edge_value", -1, int'(res.edge_value));
			end else begin
				oldest = expected_edges.pop_front();
				if (res.edge_value !== oldest.edge_value) begin
					report_mismatch("edge_value", int'(oldest.edge_value), int'(res.edge_value));
				end
				if (res.window_valid !== oldest.window_valid) begin
					report_mismatch("window_valid", int'(oldest.window_valid),
						int'(res.window_valid));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// stimulus
	initial begin
		step_t step;
		int small_sent;
		int unsigned eff;
		int count;
		logic framed;
		logic [10:0] w;
		pix_t p;

		// reset held from time zero, released once
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows
		for (int i = 0; i < STEP_COUNT; i++) begin
			step = directed_steps[i];
			if (step.cfg) begin
				settle();
				write_reg(REG_LINE_WIDTH, 32'(step.width));
				write_reg(REG_MASK_SELECT, 32'(step.mask));
			end
			send_pixel(pix_t'{pixel: step.pixel, start_of_frame: step.sof}, step.typed,
				edge_t'{edge_value: step.exp_value, window_valid: step.exp_valid});
		end

		// random frames at small widths, each with fresh settings
		small_sent = 0;
		while (small_sent < RANDOM_ITEMS) begin
			// idling regimes: sender light, then receiver light, then none
			if (small_sent >= 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (small_sent >= RANDOM_ITEMS / 3) begin
				send_idle_pct = 54;
				recv_idle_pct = 16;
			end
			// widths below 3 and above the maximum clamp
			case ($urandom_range(0, 9))
				0: w = 11'd0;
				1: w = 11'd1;
				2: w = 11'd2;
				3: w = 11'h7FF;
				default: w = 11'($urandom_range(3, 12));
			endcase
			eff = (w < 3) ? 3 : int'(w);
			if (w == 11'h7FF) begin
				count = $urandom_range(10, 30);
			end else begin
				count = eff * $urandom_range(3, 5) + $urandom_range(0, eff - 1);
			end
			// unframed phases continue mid-line, possibly past a lowered width
			framed = ($urandom_range(0, 9) < 7);
			settle();
			write_reg(REG_LINE_WIDTH, 32'(w));
			write_reg(REG_MASK_SELECT, 32'($urandom_range(0, 3)));
			for (int i = 0; i < count; i++) begin
				p.pixel = ($urandom_range(0, 9) == 0) ? {8{$urandom_range(0, 1) == 1}}
					: 8'($urandom);
				// stray start marks break frames now and then
				p.start_of_frame = (framed && i == 0) || ($urandom_range(0, 99) < 3);
				send_pixel(p, 1'b0, '0);
				small_sent++;
			end
		end

		// first row of a frame at the widest line, long enough to use the upper column bits
		settle();
		write_reg(REG_LINE_WIDTH, 32'(MAX_LINE_WIDTH));
		write_reg(REG_MASK_SELECT, 32'($urandom_range(0, 3)));
		count = MAX_LINE_WIDTH / 2 + $urandom_range(8, 40);
		for (int i = 0; i < count; i++) begin
			p.pixel = 8'($urandom);
			p.start_of_frame = (i == 0);
			send_pixel(p, 1'b0, '0);
		end

		// drain and let the pipeline run dry
		settle();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && expected_edges.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
